### hdl/rmq_pkg.sv
// rotation matrix to quaternion: shared widths, codes and payload types
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int DataW  = 16;             // q2.14 field width
  localparam int SumW   = 19;             // trace and branch sums before the clamp
  localparam int AW     = 17;             // clamped square-root argument
  localparam int RadW   = 48;             // radicand, argument shifted up by 30
  localparam int RadSh  = 30;
  localparam int RootW  = 24;             // integer root, one bit per stage
  localparam int RemW   = RootW + 2;      // partial remainder of the root
  localparam int NumW   = 18;             // off-diagonal sum or difference
  localparam int MagW   = 17;             // magnitude of a numerator
  localparam int FracSh = 21;             // numerator scale before the divide
  localparam int DvdW   = 39;             // dividend with rounding term
  localparam int QuoW   = 17;             // quotient bits below the overflow test
  localparam int DivW   = RootW + QuoW;   // widest shifted divisor
  localparam int DivStg = QuoW + 2;       // prep, overflow test, one stage per bit
  localparam int Lanes  = 3;

  localparam logic signed [SumW-1:0] QOne = 19'sd16384;

  typedef enum logic [1:0] {
    SEL_W,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef logic signed [NumW-1:0]  num_t;
  typedef logic signed [DataW-1:0] q14_t;

  // numerators in output order x, y, z, w with the branch's own component left out
  typedef struct packed {
    sel_t sel;
    num_t n0;
    num_t n1;
    num_t n2;
  } side_t;

  typedef struct packed {
    sel_t sel;
    q14_t diag;
    q14_t l0;
    q14_t l1;
    q14_t l2;
  } res_t;

endpackage

### hdl/rmq_if.sv
// valid/ready channels of the block: matrix in, quaternion out
// depends on rmq_pkg
`timescale 1ns / 1ps

interface rmq_mat_if;
  logic                valid;
  logic                ready;
  rmq_pkg::q14_t       e00, e01, e02, e10, e11, e12, e20, e21, e22;

  modport source (output valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  input ready);
  modport sink   (input valid, e00, e01, e02, e10, e11, e12, e20, e21, e22,
                  output ready);
endinterface

interface rmq_quat_if;
  logic                valid;
  logic                ready;
  rmq_pkg::q14_t       quat_x, quat_y, quat_z, quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### hdl/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage, sideband carried along
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [rmq_pkg::RadW-1:0]   rad_in,
  input  rmq_pkg::side_t             side_in,
  output logic                       vld_out,
  output logic [rmq_pkg::RootW-1:0]  root_out,
  output rmq_pkg::side_t             side_out
);
  import rmq_pkg::*;

  logic             vld    [RootW];
  logic [RadW-1:0]  rad    [RootW];
  logic [RemW-1:0]  rem    [RootW];
  logic [RootW-1:0] root   [RootW];
  side_t            side   [RootW];

  logic [RadW-1:0]  rad_n  [RootW];
  logic [RemW-1:0]  rem_n  [RootW];
  logic [RootW-1:0] root_n [RootW];

  always_comb begin
    logic [RadW-1:0]  rad_p;
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    for (int s = 0; s < RootW; s++) begin
      if (s == 0) begin
        rad_p  = rad_in;
        rem_p  = '0;
        root_p = '0;
      end else begin
        rad_p  = rad[s-1];
        rem_p  = rem[s-1];
        root_p = root[s-1];
      end
      // bring down two radicand bits, try root*4+1
      rem_sh   = {rem_p[RemW-3:0], rad_p[RadW-1 -: 2]};
      trial    = {root_p, 2'b01};
      rad_n[s] = rad_p << 2;
      if (rem_sh >= trial) begin
        rem_n[s]  = rem_sh - trial;
        root_n[s] = {root_p[RootW-2:0], 1'b1};
      end else begin
        rem_n[s]  = rem_sh;
        root_n[s] = {root_p[RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < RootW; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
      for (int s = 1; s < RootW; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int s = 1; s < RootW; s++) side[s] <= side[s-1];
      for (int s = 0; s < RootW; s++) begin
        rad[s]  <= rad_n[s];
        rem[s]  <= rem_n[s];
        root[s] <= root_n[s];
      end
    end
  end

  assign vld_out  = vld[RootW-1];
  assign root_out = root[RootW-1];
  assign side_out = side[RootW-1];

endmodule

### hdl/rmq_div.sv
// three pipelined restoring dividers sharing one divisor, plus the diagonal term
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       vld_in,
  input  logic [rmq_pkg::RootW-1:0]  root_in,
  input  rmq_pkg::side_t             side_in,
  output logic                       vld_out,
  output rmq_pkg::res_t              res_out
);
  import rmq_pkg::*;

  logic             vld   [DivStg];
  logic [RootW-1:0] root  [DivStg];
  sel_t             sel   [DivStg];
  q14_t             diag  [DivStg];
  logic [DvdW-1:0]  rem   [DivStg][Lanes];
  logic [QuoW-1:0]  quo   [DivStg][Lanes];
  logic             ovf   [DivStg][Lanes];
  logic             neg   [DivStg][Lanes];

  logic [DvdW-1:0]  rem_n [DivStg][Lanes];
  logic [QuoW-1:0]  quo_n [DivStg][Lanes];
  logic             ovf_n [DivStg][Lanes];
  logic             neg_n [DivStg][Lanes];

  num_t             nums  [Lanes];
  logic [RootW:0]   diag_sum;
  q14_t             lane_q [Lanes];

  assign nums[0]  = side_in.n0;
  assign nums[1]  = side_in.n1;
  assign nums[2]  = side_in.n2;
  // root stays below 2^24 and the argument below 114688, so r/512 never saturates
  assign diag_sum = {1'b0, root_in} + (RootW+1)'(256);

  always_comb begin
    logic [MagW-1:0] mag;
    logic [DivW-1:0] dvs;
    int              k;
    for (int l = 0; l < Lanes; l++) begin
      // prep: magnitude scaled by 2^21 plus half the divisor for rounding
      neg_n[0][l] = nums[l][NumW-1];
      mag         = MagW'(nums[l][NumW-1] ? -nums[l] : nums[l]);
      rem_n[0][l] = {mag, {FracSh{1'b0}}} + DvdW'(root_in[RootW-1:1]);
      quo_n[0][l] = '0;
      ovf_n[0][l] = 1'b0;
      // quotient of 2^17 or more saturates whatever the sign
      neg_n[1][l] = neg[0][l];
      rem_n[1][l] = rem[0][l];
      quo_n[1][l] = '0;
      ovf_n[1][l] = DivW'(rem[0][l]) >= {root[0], {QuoW{1'b0}}};
      for (int s = 2; s < DivStg; s++) begin
        k           = DivStg - 1 - s;
        dvs         = DivW'(root[s-1]) << k;
        neg_n[s][l] = neg[s-1][l];
        ovf_n[s][l] = ovf[s-1][l];
        if (!ovf[s-1][l] && DivW'(rem[s-1][l]) >= dvs) begin
          rem_n[s][l] = rem[s-1][l] - dvs[DvdW-1:0];
          quo_n[s][l] = quo[s-1][l] | (QuoW'(1) << k);
        end else begin
          rem_n[s][l] = rem[s-1][l];
          quo_n[s][l] = quo[s-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DivStg; s++) vld[s] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_in;
      for (int s = 1; s < DivStg; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root[0] <= root_in;
      sel[0]  <= side_in.sel;
      diag[0] <= q14_t'(diag_sum[RootW:9]);
      for (int s = 1; s < DivStg; s++) begin
        root[s] <= root[s-1];
        sel[s]  <= sel[s-1];
        diag[s] <= diag[s-1];
      end
      for (int s = 0; s < DivStg; s++) begin
        for (int l = 0; l < Lanes; l++) begin
          rem[s][l] <= rem_n[s][l];
          quo[s][l] <= quo_n[s][l];
          ovf[s][l] <= ovf_n[s][l];
          neg[s][l] <= neg_n[s][l];
        end
      end
    end
  end

  // sign and saturate to q2.14
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (neg[DivStg-1][l]) begin
        if (ovf[DivStg-1][l] || quo[DivStg-1][l] >= QuoW'(32768)) lane_q[l] = 16'sh8000;
        else lane_q[l] = q14_t'(-quo[DivStg-1][l]);
      end else begin
        if (ovf[DivStg-1][l] || quo[DivStg-1][l] > QuoW'(32767)) lane_q[l] = 16'sh7fff;
        else lane_q[l] = q14_t'(quo[DivStg-1][l]);
      end
    end
  end

  assign vld_out      = vld[DivStg-1];
  assign res_out.sel  = sel[DivStg-1];
  assign res_out.diag = diag[DivStg-1];
  assign res_out.l0   = lane_q[0];
  assign res_out.l1   = lane_q[1];
  assign res_out.l2   = lane_q[2];

endmodule

### hdl/rotation_matrix_to_quaternion_top.sv
// rotation matrix (q2.14) to unit quaternion (q2.14), four-branch method
// depends on rmq_pkg, rmq_if, rmq_sqrt, rmq_div
//
//   channel | dir | fields                          | transfer when
//   mat     | in  | e00 e01 e02 e10 e11 e12 e20..22 | mat.valid & mat.ready
//   quat    | out | quat_x quat_y quat_z quat_w     | quat.valid & quat.ready
//
// one matrix per cycle while results are taken; stages: branch select, 24 root stages,
// 19 divider stages (prep, overflow test, 17 quotient bits), output register
// the pipeline moves as a whole: it halts only while a result sits in the
// output register and is not taken, so nothing is dropped or repeated
// synchronous reset clears the valid bits only
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_top (
  input logic        clk,
  input logic        rst,
  rmq_mat_if.sink    mat,
  rmq_quat_if.source quat
);
  import rmq_pkg::*;

  logic                   en;

  // branch selection and numerator sums
  logic signed [SumW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [SumW-1:0] trace, a_sel;
  sel_t                   sel_next;
  side_t                  side_next;
  logic [AW-1:0]          a_next;

  // first stage registers
  logic                   vld0;
  logic [AW-1:0]          a0;
  side_t                  side0;

  // between the units
  logic                   vld_s;
  logic [RootW-1:0]       root_s;
  side_t                  side_s;
  logic                   vld_d;
  res_t                   res_d;

  // whole pipeline steps unless a finished result is held up
  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;

  assign m00 = SumW'(mat.e00);
  assign m01 = SumW'(mat.e01);
  assign m02 = SumW'(mat.e02);
  assign m10 = SumW'(mat.e10);
  assign m11 = SumW'(mat.e11);
  assign m12 = SumW'(mat.e12);
  assign m20 = SumW'(mat.e20);
  assign m21 = SumW'(mat.e21);
  assign m22 = SumW'(mat.e22);
  assign trace = m00 + m11 + m22;

  // strict compares: ties fall through to the later diagonal
  always_comb begin
    if (trace > 0) sel_next = SEL_W;
    else if (m00 > m11 && m00 > m22) sel_next = SEL_X;
    else if (m11 > m22) sel_next = SEL_Y;
    else sel_next = SEL_Z;
  end

  // argument of the root and the numerators, ordered x, y, z, w
  always_comb begin
    side_next.sel = sel_next;
    case (sel_next)
      SEL_W: begin
        a_sel        = trace + QOne;
        side_next.n0 = num_t'(m21 - m12);
        side_next.n1 = num_t'(m02 - m20);
        side_next.n2 = num_t'(m10 - m01);
      end
      SEL_X: begin
        a_sel        = QOne + m00 - m11 - m22;
        side_next.n0 = num_t'(m01 + m10);
        side_next.n1 = num_t'(m02 + m20);
        side_next.n2 = num_t'(m21 - m12);
      end
      SEL_Y: begin
        a_sel        = QOne + m11 - m00 - m22;
        side_next.n0 = num_t'(m01 + m10);
        side_next.n1 = num_t'(m12 + m21);
        side_next.n2 = num_t'(m02 - m20);
      end
      default: begin
        a_sel        = QOne + m22 - m00 - m11;
        side_next.n0 = num_t'(m02 + m20);
        side_next.n1 = num_t'(m12 + m21);
        side_next.n2 = num_t'(m10 - m01);
      end
    endcase
    // malformed matrix: keep the root away from zero
    if (a_sel < 1) a_next = AW'(1);
    else a_next = a_sel[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) vld0 <= 1'b0;
    else if (en) vld0 <= mat.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= a_next;
      side0 <= side_next;
    end
  end

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (vld0),
    .rad_in   ({1'b0, a0, {RadSh{1'b0}}}),
    .side_in  (side0),
    .vld_out  (vld_s),
    .root_out (root_s),
    .side_out (side_s)
  );

  rmq_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (vld_s),
    .root_in (root_s),
    .side_in (side_s),
    .vld_out (vld_d),
    .res_out (res_d)
  );

  // output register: put the branch's own component in its place
  always_ff @(posedge clk) begin
    if (rst) quat.valid <= 1'b0;
    else if (en) quat.valid <= vld_d;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (res_d.sel)
        SEL_W: begin
          quat.quat_x <= res_d.l0;
          quat.quat_y <= res_d.l1;
          quat.quat_z <= res_d.l2;
          quat.quat_w <= res_d.diag;
        end
        SEL_X: begin
          quat.quat_x <= res_d.diag;
          quat.quat_y <= res_d.l0;
          quat.quat_z <= res_d.l1;
          quat.quat_w <= res_d.l2;
        end
        SEL_Y: begin
          quat.quat_x <= res_d.l0;
          quat.quat_y <= res_d.diag;
          quat.quat_z <= res_d.l1;
          quat.quat_w <= res_d.l2;
        end
        default: begin
          quat.quat_x <= res_d.l0;
          quat.quat_y <= res_d.l1;
          quat.quat_z <= res_d.diag;
          quat.quat_w <= res_d.l2;
        end
      endcase
    end
  end

endmodule
